// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL files that check their own logic.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/pcxrle_pkg.sv -----
// Types, constants and run-closing helper for the PCX-style RLE encoder.
// No dependencies; used by every module of the block.
package pcxrle_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic REG_RUN_MODE   = 1'b0;
    localparam logic REG_HEADER_LEN = 1'b1;

    localparam int HDR_W = 10;
    localparam int LEN_W = 7;

    // One accepted item's worth of output bytes, byte 0 first.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      last_idx;
        logic            last;
    } grp_t;

    typedef struct packed {
        logic [1:0]  n;
        logic [15:0] word;
    } close_t;

    function automatic logic [7:0] mode_base(input logic [1:0] mode);
        logic [7:0] b;
        case (mode)
            2'd0:    b = 8'd192;
            2'd1:    b = 8'd224;
            2'd2:    b = 8'd240;
            default: b = 8'd248;
        endcase
        return b;
    endfunction

    function automatic logic [LEN_W-1:0] mode_max(input logic [1:0] mode);
        logic [LEN_W-1:0] m;
        case (mode)
            2'd0:    m = 7'd64;
            2'd1:    m = 7'd32;
            2'd2:    m = 7'd16;
            default: m = 7'd8;
        endcase
        return m;
    endfunction

    // Bytes emitted when a run of len copies of val closes.
    function automatic close_t close_run(input logic [LEN_W-1:0] len,
                                         input logic [7:0] val,
                                         input logic [7:0] base);
        close_t c;
        c.n    = 2'd0;
        c.word = 16'd0;
        if (len >= 7'd2) begin
            c.n    = 2'd2;
            c.word = {val, 8'(base + {1'b0, len} - 8'd1)};
        end
        else if (len == 7'd1) begin
            if (val < base) begin
                c.n    = 2'd1;
                c.word = {8'd0, val};
            end
            else begin
                c.n    = 2'd2;
                c.word = {val, base};
            end
        end
        return c;
    endfunction

endpackage

// ----- src/pcxrle_front.sv -----
// Front end: accepts input items, tracks header and run state, and
// builds each item's output group. Depends on pcxrle_pkg.
module pcxrle_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    run_mode,
    input  logic [pcxrle_pkg::HDR_W-1:0]  header_len,
    input  logic                          accept,
    input  logic [7:0]                    in_byte,
    input  logic                          in_last,
    output logic                          grp_valid,
    output pcxrle_pkg::grp_t              grp
);

    logic [pcxrle_pkg::HDR_W-1:0] pos_reg,  pos_next;
    logic [7:0]                   held_reg, held_next;
    logic [pcxrle_pkg::LEN_W-1:0] len_reg,  len_next;

    logic [7:0]                   base;
    logic                         in_hdr;
    logic                         extend;
    logic [pcxrle_pkg::LEN_W-1:0] run_len;
    logic [7:0]                   run_val;
    pcxrle_pkg::close_t           close_a;
    pcxrle_pkg::close_t           close_b;
    logic [2:0]                   total;
    logic [31:0]                  word;

    always_comb
    begin
        base    = pcxrle_pkg::mode_base(run_mode);
        in_hdr  = pos_reg < header_len;
        extend  = (len_reg != '0) && (in_byte == held_reg)
                  && (len_reg < pcxrle_pkg::mode_max(run_mode));
        run_len = extend ? len_reg + 7'd1 : 7'd1;
        run_val = extend ? held_reg : in_byte;

        close_a = pcxrle_pkg::close_run(extend ? '0 : len_reg, held_reg, base);
        close_b = pcxrle_pkg::close_run(in_last ? run_len : '0, run_val, base);

        if (in_hdr) begin
            total = 3'd1;
            word  = {24'd0, in_byte};
        end
        else begin
            total = {1'b0, close_a.n} + {1'b0, close_b.n};
            word  = {16'd0, close_a.word}
                    | ({16'd0, close_b.word} << {close_a.n, 3'b000});
        end

        grp.data     = word;
        grp.last_idx = 2'(total - 3'd1);
        grp.last     = in_last;
        grp_valid    = accept && (total != 3'd0);

        pos_next  = pos_reg;
        held_next = held_reg;
        len_next  = len_reg;
        if (accept) begin
            if (in_last) begin
                pos_next  = '0;
                held_next = '0;
                len_next  = '0;
            end
            else if (in_hdr) begin
                pos_next = pos_reg + 10'd1;
            end
            else begin
                held_next = run_val;
                len_next  = run_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= '0;
            held_reg <= '0;
            len_reg  <= '0;
        end
        else begin
            pos_reg  <= pos_next;
            held_reg <= held_next;
            len_reg  <= len_next;
        end
    end

endmodule

// ----- src/pcxrle_queue.sv -----
// Short queue of output groups between the front and back ends.
// Depends on pcxrle_pkg for the group type.
module pcxrle_queue #(
    parameter int DEPTH = pcxrle_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  pcxrle_pkg::grp_t  wr_grp,
    output logic              q_full,
    input  logic              rd_en,
    output pcxrle_pkg::grp_t  rd_grp,
    output logic              q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcxrle_pkg::grp_t  slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic              do_wr, do_rd;

    always_comb
    begin
        q_full  = cnt_reg == CNT_W'(DEPTH);
        q_empty = cnt_reg == '0;
        do_wr   = wr_en && !q_full;
        do_rd   = rd_en && !q_empty;
        rd_grp  = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_grp;
        end
    end

endmodule

// ----- src/pcxrle_back.sv -----
// Back end: walks the head group of the queue one byte per pop.
// Depends on pcxrle_pkg for the group type.
module pcxrle_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pcxrle_pkg::grp_t  head,
    input  logic              q_empty,
    output logic              q_rd,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        out_byte,
    output logic              group_last,
    output logic              stream_end
);

    logic [1:0] idx_reg, idx_next;
    logic       take;

    always_comb
    begin
        empty      = q_empty;
        out_byte   = head.data[idx_reg];
        group_last = idx_reg == head.last_idx;
        stream_end = group_last && head.last;
        take       = pop && !q_empty;
        q_rd       = take && group_last;

        idx_next = idx_reg;
        if (take) begin
            idx_next = group_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= '0;
        end
        else begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ----- src/pcx_style_rle_encoder_top.sv -----
// Top level of the PCX-style RLE encoder: config registers, front, queue, back.
// Depends on pcxrle_pkg, pcxrle_front, pcxrle_queue, pcxrle_back, assert_macros.svh.
//
//  channel   direction  handshake                 payload
//  input     in         push / full               in_byte, in_last
//  result    out        empty / pop               out_byte, group_last, stream_end
//  config    in/out     psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// An item is taken whenever push is high and the group queue has room; it is
// classified as it is taken and its 0 to 4 bytes land in the queue.
// The back end sends one byte per cycle while pop is high and the queue holds
// a group, so the bytes of each item leave one at a time on the single output port.
// Reset clears run state, queue and registers at once; no clearing pass.
// A stalled result side fills the queue (QUEUE_DEPTH groups) and then raises full.
`include "assert_macros.svh"

module pcx_style_rle_encoder_top #(
    parameter int QUEUE_DEPTH = pcxrle_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        group_last,
    output logic        stream_end
);

    logic [1:0]                   run_mode_reg, run_mode_next;
    logic [pcxrle_pkg::HDR_W-1:0] header_len_reg, header_len_next;
    logic                         cfg_wr;
    logic                         accept;
    logic                         grp_valid;
    pcxrle_pkg::grp_t             grp;
    pcxrle_pkg::grp_t             head;
    logic                         q_full;
    logic                         q_empty;
    logic                         q_rd;

    always_comb
    begin
        pready          = 1'b1;
        cfg_wr          = psel && penable && pwrite;
        run_mode_next   = run_mode_reg;
        header_len_next = header_len_reg;
        prdata          = '0;
        unique case (paddr[2])
            pcxrle_pkg::REG_RUN_MODE:
            begin
                prdata = {30'd0, run_mode_reg};
                if (cfg_wr) begin
                    run_mode_next = pwdata[1:0];
                end
            end
            pcxrle_pkg::REG_HEADER_LEN:
            begin
                prdata = {22'd0, header_len_reg};
                if (cfg_wr) begin
                    header_len_next = pwdata[pcxrle_pkg::HDR_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_mode_reg   <= '0;
            header_len_reg <= '0;
        end
        else begin
            run_mode_reg   <= run_mode_next;
            header_len_reg <= header_len_next;
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    pcxrle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .run_mode   (run_mode_reg),
        .header_len (header_len_reg),
        .accept     (accept),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .grp_valid  (grp_valid),
        .grp        (grp)
    );

    pcxrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (grp_valid),
        .wr_grp  (grp),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .rd_grp  (head),
        .q_empty (q_empty)
    );

    pcxrle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .q_rd       (q_rd),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .group_last (group_last),
        .stream_end (stream_end)
    );

    // A last item always yields at least one byte.
    `CHK_NEXT(a_last_gives_item, push && !full && in_last, !empty, "last item produced no result")
    `CHK_SAME(a_full_not_empty, full, !empty, "queue full and empty together")
    `CHK_SAME(a_end_closes_group, !empty && stream_end, group_last, "stream end inside a group")

endmodule
